/* sv/lpbd_pkg.sv */
// Shared types, codes and constants of the length-prefixed blob deframer.
package lpbd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [31:0] proof_number;
        logic        proof_end;
        logic        blob_done;
        logic [2:0]  status;
    } result_t;

    // Parser phases
    localparam logic [2:0] PH_COUNT_PREFIX = 3'd0;
    localparam logic [2:0] PH_COUNT_EXT    = 3'd1;
    localparam logic [2:0] PH_LEN_PREFIX   = 3'd2;
    localparam logic [2:0] PH_LEN_EXT      = 3'd3;
    localparam logic [2:0] PH_PAYLOAD      = 3'd4;
    localparam logic [2:0] PH_DONE         = 3'd5;
    localparam logic [2:0] PH_SWALLOW      = 3'd6;

    // Blob status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_NONCANON = 3'd2;
    localparam logic [2:0] ST_TRAILING = 3'd3;
    localparam logic [2:0] ST_TOOLARGE = 3'd4;

    // CompactSize forms
    localparam logic [1:0] FORM_8  = 2'd0;
    localparam logic [1:0] FORM_16 = 2'd1;
    localparam logic [1:0] FORM_32 = 2'd2;
    localparam logic [1:0] FORM_64 = 2'd3;

    localparam logic [7:0] SIZE_PREFIX_MIN = 8'd253;
    localparam logic [7:0] PREFIX_16       = 8'hFD;
    localparam logic [7:0] PREFIX_32       = 8'hFE;

    localparam logic [63:0] COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

    // Smallest value each form may carry under the shortest-form rule
    localparam logic [63:0] FORM_MIN [4] = '{
        64'd0,
        64'd253,
        64'h0000_0000_0001_0000,
        64'h0000_0001_0000_0000
    };

    function automatic logic [3:0] form_len(input logic [1:0] form);
        logic [3:0] len;
        case (form)
            FORM_8:  len = 4'd0;
            FORM_16: len = 4'd2;
            FORM_32: len = 4'd4;
            default: len = 4'd8;
        endcase
        return len;
    endfunction

endpackage

/* sv/lpbd_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
interface lpbd_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/lpbd_in_reg.sv */
// Input register stage: holds one accepted byte until the parser takes it.
module lpbd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    lpbd_stream_if.sink         blob,
    input  logic                taken,
    output logic                item_valid,
    output lpbd_pkg::in_item_t  item
);
    logic               valid_reg;
    logic               valid_next;
    lpbd_pkg::in_item_t item_reg;
    logic               load;

    assign blob.ready = !valid_reg || taken;
    assign load       = blob.valid && blob.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= blob.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

/* sv/lpbd_parser.sv */
// CompactSize framing state machine: one byte per cycle unless a result finds no room, at most one result.
module lpbd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  lpbd_pkg::in_item_t  item,
    input  logic                out_room,
    output logic                taken,
    output logic                res_valid,
    output lpbd_pkg::result_t   res
);
    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  left_reg,    left_next;
    logic [63:0] acc_reg,     acc_next;
    logic [1:0]  form_reg,    form_next;
    logic [31:0] proofs_reg,  proofs_next;
    logic [31:0] cur_reg,     cur_next;
    logic [63:0] pay_reg,     pay_next;
    logic [2:0]  err_reg,     err_next;

    logic [7:0]  b;
    logic [2:0]  lane_idx;
    logic [63:0] acc_lane;
    logic [63:0] pay_dec;
    logic [63:0] size_val;
    logic        size_done;
    logic        is_count;
    logic        advance;
    logic        emit;

    assign b        = item.data_byte;
    assign lane_idx = 3'(lpbd_pkg::form_len(form_reg) - left_reg);
    assign pay_dec  = pay_reg - 64'd1;
    assign is_count = phase_reg inside {lpbd_pkg::PH_COUNT_PREFIX, lpbd_pkg::PH_COUNT_EXT};

    // Drop the byte into its little-endian lane
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            acc_lane[8*i +: 8] = (lane_idx == 3'(i)) ? b : acc_reg[8*i +: 8];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        form_next   = form_reg;
        proofs_next = proofs_reg;
        cur_next    = cur_reg;
        pay_next    = pay_reg;
        err_next    = err_reg;
        size_done   = 1'b0;
        size_val    = acc_lane;
        advance     = 1'b0;
        emit        = 1'b0;
        res         = '0;

        case (phase_reg)
            lpbd_pkg::PH_COUNT_PREFIX, lpbd_pkg::PH_LEN_PREFIX:
            begin
                if (b < lpbd_pkg::SIZE_PREFIX_MIN)
                begin
                    size_done = 1'b1;
                    size_val  = {56'd0, b};
                    acc_next  = {56'd0, b};
                    form_next = lpbd_pkg::FORM_8;
                    left_next = 4'd0;
                end
                else
                begin
                    form_next = (b == lpbd_pkg::PREFIX_16) ? lpbd_pkg::FORM_16 :
                                (b == lpbd_pkg::PREFIX_32) ? lpbd_pkg::FORM_32 :
                                                             lpbd_pkg::FORM_64;
                    left_next  = lpbd_pkg::form_len(form_next);
                    acc_next   = '0;
                    phase_next = (phase_reg == lpbd_pkg::PH_COUNT_PREFIX) ?
                                 lpbd_pkg::PH_COUNT_EXT : lpbd_pkg::PH_LEN_EXT;
                end
            end
            lpbd_pkg::PH_COUNT_EXT, lpbd_pkg::PH_LEN_EXT:
            begin
                acc_next  = acc_lane;
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    if (acc_lane < lpbd_pkg::FORM_MIN[form_reg])
                    begin
                        err_next   = lpbd_pkg::ST_NONCANON;
                        phase_next = lpbd_pkg::PH_SWALLOW;
                    end
                    else
                    begin
                        size_done = 1'b1;
                    end
                end
            end
            lpbd_pkg::PH_PAYLOAD:
            begin
                emit              = 1'b1;
                res.payload_valid = 1'b1;
                res.payload_byte  = b;
                res.proof_number  = cur_reg;
                pay_next          = pay_dec;
                if (pay_dec == 64'd0)
                begin
                    res.proof_end = 1'b1;
                    advance       = 1'b1;
                end
            end
            lpbd_pkg::PH_DONE:
            begin
                err_next   = lpbd_pkg::ST_TRAILING;
                phase_next = lpbd_pkg::PH_SWALLOW;
            end
            default:
            begin
                // swallow until the final byte
            end
        endcase

        if (size_done)
        begin
            if (is_count)
            begin
                if (size_val > lpbd_pkg::COUNT_MAX)
                begin
                    err_next   = lpbd_pkg::ST_TOOLARGE;
                    phase_next = lpbd_pkg::PH_SWALLOW;
                end
                else
                begin
                    proofs_next = size_val[31:0];
                    cur_next    = '0;
                    phase_next  = (size_val[31:0] != 32'd0) ?
                                  lpbd_pkg::PH_LEN_PREFIX : lpbd_pkg::PH_DONE;
                end
            end
            else if (size_val == 64'd0)
            begin
                emit             = 1'b1;
                res.proof_end    = 1'b1;
                res.proof_number = cur_reg;
                advance          = 1'b1;
            end
            else
            begin
                pay_next   = size_val;
                phase_next = lpbd_pkg::PH_PAYLOAD;
            end
        end

        if (advance)
        begin
            cur_next    = cur_reg + 32'd1;
            proofs_next = proofs_reg - 32'd1;
            phase_next  = (proofs_reg != 32'd1) ? lpbd_pkg::PH_LEN_PREFIX : lpbd_pkg::PH_DONE;
        end

        if (item.final_byte)
        begin
            emit          = 1'b1;
            res.blob_done = 1'b1;
            res.status    = (err_next != lpbd_pkg::ST_OK) ? err_next :
                            (phase_next == lpbd_pkg::PH_DONE) ? lpbd_pkg::ST_OK :
                                                                lpbd_pkg::ST_TRUNC;
        end
    end

    // A byte with no result needs no room downstream
    assign taken     = item_valid && (out_room || !emit);
    assign res_valid = taken && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lpbd_pkg::PH_COUNT_PREFIX;
            left_reg   <= '0;
            acc_reg    <= '0;
            form_reg   <= lpbd_pkg::FORM_8;
            proofs_reg <= '0;
            cur_reg    <= '0;
            pay_reg    <= '0;
            err_reg    <= lpbd_pkg::ST_OK;
        end
        else if (taken)
        begin
            if (item.final_byte)
            begin
                // return to the start of a new blob
                phase_reg  <= lpbd_pkg::PH_COUNT_PREFIX;
                left_reg   <= '0;
                acc_reg    <= '0;
                form_reg   <= lpbd_pkg::FORM_8;
                proofs_reg <= '0;
                cur_reg    <= '0;
                pay_reg    <= '0;
                err_reg    <= lpbd_pkg::ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                acc_reg    <= acc_next;
                form_reg   <= form_next;
                proofs_reg <= proofs_next;
                cur_reg    <= cur_next;
                pay_reg    <= pay_next;
                err_reg    <= err_next;
            end
        end
    end
endmodule

/* sv/lpbd_out_reg.sv */
// Result register stage: holds one result beat until the receiver takes it.
module lpbd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  lpbd_pkg::result_t  res,
    output logic               out_room,
    lpbd_stream_if.source      result
);
    logic              valid_reg;
    lpbd_pkg::result_t data_reg;

    assign out_room = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_room && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid = valid_reg;
    assign result.data  = data_reg;
endmodule

/* sv/length_prefixed_blob_deframer.sv */
// Length-prefixed blob deframer: CompactSize proof count, then length-prefixed proofs.
//
// Usage:
//   blob   : sink stream of bytes (data_byte, final_byte flags the last byte).
//   result : source stream of results (payload byte with proof number, proof
//            end marker, and blob_done with status on the final byte).
//   A byte that yields no result (size prefix bytes, swallowed bytes) is
//   consumed silently.
// Path: an accepted byte is held in the input register and parsed out of it;
//   its result is captured in the result register once that has room.
// Throughput: one byte per cycle while the result register has room for each
//   result; a byte that yields no result is never held.
// Stall: when the receiver holds result.ready low, the result register keeps
//   its beat; bytes that produce no result still drain, and the input register
//   then holds one further byte that needs a result before blob.ready drops.
// Reset: rst_n clears both stage valid bits and returns the parser to the
//   start of a blob. The parser also returns there after every final byte.
module length_prefixed_blob_deframer (
    input  logic          clk,
    input  logic          rst_n,
    lpbd_stream_if.sink   blob,
    lpbd_stream_if.source result
);
    logic               item_valid;
    lpbd_pkg::in_item_t item;
    logic               taken;
    logic               res_valid;
    lpbd_pkg::result_t  res;
    logic               out_room;

    lpbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .blob       (blob),
        .taken      (taken),
        .item_valid (item_valid),
        .item       (item)
    );

    lpbd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_room   (out_room),
        .taken      (taken),
        .res_valid  (res_valid),
        .res        (res)
    );

    lpbd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_room  (out_room),
        .result    (result)
    );

    // Status only travels with the blob's final beat
    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.blob_done) |-> (result.data.status == lpbd_pkg::ST_OK))
        else $error("status set on a beat without blob_done");

    // Every result beat carries something
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.data.payload_valid || result.data.proof_end || result.data.blob_done))
        else $error("empty result beat");

    // A byte the parser could not take stays put in the input register
    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !taken) |=> (item_valid && $stable(item)))
        else $error("unparsed byte lost from input register");

    // A result is only produced when the result register has room for it
    a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_room)
        else $error("result produced with no room in result register");
endmodule

/* tb/sv/deframer_result_check.sv */
// Byte-level deframer predictor and result comparator for the blob deframer bench.
`timescale 1ns / 1ps

module deframer_result_check
    import lpbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     blob_valid,
    input  logic     blob_ready,
    input  in_item_t blob_data,
    input  logic     result_valid,
    input  logic     result_ready,
    input  result_t  result_data,
    output int       pending,
    output int       failures
);

    localparam int REPORT_LIMIT = 10;

    // Parser state, mirrored beat by beat
    logic [2:0]  phase      = PH_COUNT_PREFIX;
    logic [3:0]  ext_left   = '0;
    logic [63:0] size_value = '0;
    logic [1:0]  size_form  = FORM_8;
    logic [63:0] proofs_due = '0;
    logic [31:0] proof_idx  = '0;
    logic [63:0] bytes_due  = '0;
    logic [2:0]  blob_error = ST_OK;

    result_t     expected_results [$];
    int          mismatch_count = 0;

    function automatic logic [3:0] ext_len(input logic [1:0] form);
        logic [3:0] n;
        case (form)
            FORM_16: n = 4'd2;
            FORM_32: n = 4'd4;
            FORM_64: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic void restart_blob();
        phase      = PH_COUNT_PREFIX;
        ext_left   = '0;
        size_value = '0;
        size_form  = FORM_8;
        proofs_due = '0;
        proof_idx  = '0;
        bytes_due  = '0;
        blob_error = ST_OK;
    endfunction

    // Advance the parser by one beat; returns 1 when the beat yields a result.
    function automatic bit deframe_byte(input in_item_t beat, output result_t res);
        logic [7:0]  b;
        logic        size_ready;
        logic        is_count;
        logic        close_proof;
        logic [3:0]  ext_total;
        logic [63:0] shortest_min;
        bit          emit;

        b           = beat.data_byte;
        res         = '0;
        emit        = 1'b0;
        size_ready  = 1'b0;
        is_count    = 1'b0;
        close_proof = 1'b0;

        case (phase)
            PH_COUNT_PREFIX, PH_LEN_PREFIX:
            begin
                is_count = (phase == PH_COUNT_PREFIX);
                if (b < 8'd253)
                begin
                    size_value = {56'd0, b};
                    size_form  = FORM_8;
                    ext_left   = '0;
                    size_ready = 1'b1;
                end
                else
                begin
                    size_form  = (b == PREFIX_16) ? FORM_16 : (b == PREFIX_32) ? FORM_32 : FORM_64;
                    ext_left   = ext_len(size_form);
                    size_value = '0;
                    phase      = is_count ? PH_COUNT_EXT : PH_LEN_EXT;
                end
            end
            PH_COUNT_EXT, PH_LEN_EXT:
            begin
                is_count   = (phase == PH_COUNT_EXT);
                ext_total  = ext_len(size_form);
                size_value = size_value | ({56'd0, b} << (8 * ((ext_total - ext_left) & 4'd7)));
                ext_left   = ext_left - 4'd1;
                if (ext_left == 4'd0)
                begin
                    shortest_min = (size_form == FORM_16) ? 64'd253 :
                                   (size_form == FORM_32) ? 64'h1_0000 : 64'h1_0000_0000;
                    if (size_value < shortest_min)
                    begin
                        blob_error = ST_NONCANON;
                        phase      = PH_SWALLOW;
                    end
                    else
                    begin
                        size_ready = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit              = 1'b1;
                res.payload_valid = 1'b1;
                res.payload_byte  = b;
                res.proof_number  = proof_idx;
                bytes_due         = bytes_due - 64'd1;
                if (bytes_due == 64'd0)
                begin
                    res.proof_end = 1'b1;
                    close_proof   = 1'b1;
                end
            end
            PH_DONE:
            begin
                blob_error = ST_TRAILING;
                phase      = PH_SWALLOW;
            end
            default:
            begin
                // swallow until the final beat
            end
        endcase

        if (size_ready)
        begin
            if (is_count)
            begin
                if (size_value > 64'hFFFF_FFFF)
                begin
                    blob_error = ST_TOOLARGE;
                    phase      = PH_SWALLOW;
                end
                else
                begin
                    proofs_due = size_value;
                    proof_idx  = '0;
                    phase      = (proofs_due != 64'd0) ? PH_LEN_PREFIX : PH_DONE;
                end
            end
            else if (size_value == 64'd0)
            begin
                // empty proof closes on its length byte
                emit             = 1'b1;
                res.proof_end    = 1'b1;
                res.proof_number = proof_idx;
                close_proof      = 1'b1;
            end
            else
            begin
                bytes_due = size_value;
                phase     = PH_PAYLOAD;
            end
        end

        if (close_proof)
        begin
            proof_idx  = proof_idx + 32'd1;
            proofs_due = proofs_due - 64'd1;
            phase      = (proofs_due != 64'd0) ? PH_LEN_PREFIX : PH_DONE;
        end

        if (beat.final_byte)
        begin
            emit          = 1'b1;
            res.blob_done = 1'b1;
            res.status    = (blob_error != ST_OK) ? blob_error :
                            (phase == PH_DONE) ? ST_OK : ST_TRUNC;
            restart_blob();
        end
        return emit;
    endfunction

    function automatic void flag_result(input string why, input result_t want,
                                        input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected byte=%02h pv=%0b proof=%0d end=%0b done=%0b status=%0d",
                     $time, why, want.payload_byte, want.payload_valid, want.proof_number,
                     want.proof_end, want.blob_done, want.status);
            $display("%0t: %s: actual   byte=%02h pv=%0b proof=%0d end=%0b done=%0b status=%0d",
                     $time, why, got.payload_byte, got.payload_valid, got.proof_number,
                     got.proof_end, got.blob_done, got.status);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            restart_blob();
            expected_results.delete();
        end
        else
        begin
            // check the outgoing beat before predicting: results trail their byte
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_result("result with no byte pending", '0, result_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_data.payload_byte  !== want.payload_byte  ||
                        result_data.payload_valid !== want.payload_valid ||
                        result_data.proof_number  !== want.proof_number  ||
                        result_data.proof_end     !== want.proof_end     ||
                        result_data.blob_done     !== want.blob_done     ||
                        result_data.status        !== want.status)
                    begin
                        flag_result("result mismatch", want, result_data);
                    end
                end
            end
            if (blob_valid && blob_ready)
            begin
                if (deframe_byte(blob_data, want))
                begin
                    expected_results.insert(expected_results.size(), want);
                end
            end
        end
        pending  <= expected_results.size();
        failures <= mismatch_count;
    end

endmodule

/* tb/sv/length_prefixed_blob_deframer_tb.sv */
// Stimulus, handshake pacing and verdict for the length-prefixed blob deframer.
`timescale 1ns / 1ps

module length_prefixed_blob_deframer_tb;
    import lpbd_pkg::*;

    localparam int         CLK_PERIOD   = 10;
    localparam int         ITEM_TARGET  = 950;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_SEGMENT = 6;
    localparam int         HOLD_CYCLES  = 150;
    localparam logic [7:0] PREFIX_64    = 8'hFF;

    typedef enum int {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_PULSED,
        SINK_HOLD
    } sink_mode_t;

    typedef enum int {
        BLOB_CLEAN,
        BLOB_CUT,
        BLOB_TRAILING,
        BLOB_NONCANON,
        BLOB_TOOLARGE,
        BLOB_WIDE_CUT,
        BLOB_NOISE
    } blob_kind_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    int         failures;
    int         pending;
    int         bytes_sent     = 0;
    int         burst_left     = 0;
    int         big_len_budget = 1;
    logic [7:0] blob_bytes [$];

    lpbd_stream_if #(.payload_t(in_item_t)) blob_if ();
    lpbd_stream_if #(.payload_t(result_t))  result_if ();

    length_prefixed_blob_deframer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .blob   (blob_if),
        .result (result_if)
    );

    deframer_result_check deframer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .blob_valid   (blob_if.valid),
        .blob_ready   (blob_if.ready),
        .blob_data    (blob_if.data),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_data  (result_if.data),
        .pending      (pending),
        .failures     (failures)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Append one byte to the blob under construction
    function automatic void add_byte(input logic [7:0] b);
        blob_bytes.insert(blob_bytes.size(), b);
    endfunction

    function automatic void put_size(input logic [63:0] value, input logic [1:0] form);
        int         ext;
        logic [7:0] lead;
        lead = (form == FORM_16) ? PREFIX_16 : (form == FORM_32) ? PREFIX_32 :
               (form == FORM_64) ? PREFIX_64 : value[7:0];
        ext  = (form == FORM_16) ? 2 : (form == FORM_32) ? 4 : (form == FORM_64) ? 8 : 0;
        add_byte(lead);
        for (int i = 0; i < ext; i++)
        begin
            add_byte(value[8 * i +: 8]);
        end
    endfunction

    function automatic void put_canonical(input logic [63:0] value);
        put_size(value, (value < 64'd253) ? FORM_8 : (value < 64'h1_0000) ? FORM_16 :
                        (value < 64'h1_0000_0000) ? FORM_32 : FORM_64);
    endfunction

    // Proof count, then each proof as length and payload
    function automatic void put_clean_blob(input int proofs);
        int len;
        int pick;
        put_canonical(64'(proofs));
        for (int p = 0; p < proofs; p++)
        begin
            pick = $urandom_range(0, 99);
            if (big_len_budget > 0 && pick < 3)
            begin
                big_len_budget--;
                len = $urandom_range(253, 260);
            end
            else if (pick < 25)
            begin
                len = 0;
            end
            else
            begin
                len = $urandom_range(1, (pick < 90) ? 6 : 24);
            end
            put_canonical(64'(len));
            repeat (len) add_byte(8'($urandom));
        end
    endfunction

    function automatic void trim_blob(input int keep);
        while (blob_bytes.size() > keep)
        begin
            void'(blob_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                blob_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        blob_if.valid <= 1'b1;
        blob_if.data  <= '{data_byte: b, final_byte: fin};
        @(posedge clk);
        while (!blob_if.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        bytes_sent++;
    endtask

    // Send the assembled blob, flagging its last byte as final
    task automatic send_blob();
        for (int i = 0; i < blob_bytes.size(); i++)
        begin
            send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
        end
        blob_bytes.delete();
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((blob_if.valid && blob_if.ready) || (result_if.valid && result_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : result_sink
        sink_mode_t mode;
        int         span;
        int         segment;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        segment = 0;
        forever
        begin
            segment++;
            // one long hold-off while the sender keeps offering: fill the block
            if (segment == HOLD_SEGMENT)
            begin
                mode = SINK_HOLD;
                span = HOLD_CYCLES;
            end
            else
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 96);
            end
            for (int c = 0; c < span; c++)
            begin
                case (mode)
                    SINK_OPEN:   result_if.ready <= 1'b1;
                    SINK_MOSTLY: result_if.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
                    SINK_PULSED: result_if.ready <= ((c % 8) < 3);
                    default:     result_if.ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : blob_source
        int          r;
        logic [63:0] v;
        logic [1:0]  form;
        blob_kind_t  kind;

        blob_if.valid <= 1'b0;
        blob_if.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty blob, empty proof, payload extremes
        blob_bytes = '{8'h00};
        send_blob();
        blob_bytes = '{8'h01, 8'h00};
        send_blob();
        blob_bytes = '{8'h02, 8'h01, 8'hFF, 8'h01, 8'h00};
        send_blob();
        // count 252 written in the three-byte form
        blob_bytes = '{PREFIX_16, 8'hFC, 8'h00};
        send_blob();
        // count of exactly 2^32
        blob_bytes = '{PREFIX_64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
        send_blob();
        // byte after the last proof
        blob_bytes = '{8'h00, 8'hAB};
        send_blob();
        // final byte in the middle of a payload
        blob_bytes = '{8'h01, 8'h03, 8'h5A};
        send_blob();

        while (bytes_sent < ITEM_TARGET)
        begin
            r    = $urandom_range(0, 99);
            kind = (r < 45) ? BLOB_CLEAN : (r < 58) ? BLOB_CUT : (r < 66) ? BLOB_TRAILING :
                   (r < 76) ? BLOB_NONCANON : (r < 82) ? BLOB_TOOLARGE :
                   (r < 92) ? BLOB_WIDE_CUT : BLOB_NOISE;
            case (kind)
                BLOB_CLEAN:
                begin
                    put_clean_blob($urandom_range(0, 4));
                end
                BLOB_CUT:
                begin
                    put_clean_blob($urandom_range(1, 4));
                    trim_blob($urandom_range(1, blob_bytes.size() - 1));
                end
                BLOB_TRAILING:
                begin
                    put_clean_blob($urandom_range(0, 3));
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
                end
                BLOB_NONCANON:
                begin
                    form = 2'($urandom_range(1, 3));
                    v    = (form == FORM_16) ? 64'($urandom_range(0, 252)) :
                           (form == FORM_32) ? 64'($urandom_range(0, 65535)) : 64'($urandom);
                    if ($urandom_range(0, 2) != 0)
                    begin
                        // over-long proof length rather than over-long count
                        put_canonical(64'($urandom_range(2, 4)));
                        repeat ($urandom_range(0, 1)) put_canonical(64'd0);
                    end
                    put_size(v, form);
                    repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
                end
                BLOB_TOOLARGE:
                begin
                    v = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
                    if ($urandom_range(0, 7) == 0)
                    begin
                        v = '1;
                    end
                    put_size(v, FORM_64);
                    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                end
                BLOB_WIDE_CUT:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        put_canonical(64'($urandom_range(253, 70000)));
                        repeat ($urandom_range(0, 2)) put_canonical(64'd0);
                    end
                    else
                    begin
                        put_canonical(64'($urandom_range(1, 3)));
                        v = ($urandom_range(0, 1) == 0) ?
                            64'($urandom_range(65536, 32'hFFFF_FFFF)) :
                            {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
                        if ($urandom_range(0, 7) == 0)
                        begin
                            v = '1;
                        end
                        put_canonical(v);
                        repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
                    end
                    // sometimes cut the blob short, possibly inside the size extension bytes
                    if ($urandom_range(0, 2) == 0 && blob_bytes.size() > 1)
                    begin
                        trim_blob($urandom_range(1, blob_bytes.size() - 1));
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
                end
            endcase
            send_blob();
        end

        blob_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
